// ===== rtl/gcm_pkg.sv =====
// Shared types and constants of the greedy change maker.
package gcm_pkg;

  // Field widths.
  localparam int unsigned AMOUNT_W = 24;
  localparam int unsigned DENOM_W  = 16;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned CFG_IDX_W = 4;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DENOM_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DENOM_BASE  = 4'd1;

  // Number of denomination register slots and their reset values.
  localparam int unsigned DENOM_SLOTS = 7;
  localparam logic [COUNT_W-1:0] DENOM_COUNT_RESET = 3'd7;
  localparam logic [DENOM_W-1:0] DENOM_RESET [DENOM_SLOTS] = '{
    16'd50000, 16'd10000, 16'd2000, 16'd500, 16'd100, 16'd10, 16'd1
  };

  // Result of one division.
  typedef struct packed {
    logic [AMOUNT_W-1:0] quotient;
    logic [DENOM_W-1:0]  remainder;
  } div_res_t;

endpackage

// ===== rtl/gcm_div.sv =====
// Radix-2 restoring divider: one quotient bit per cycle.
module gcm_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [gcm_pkg::AMOUNT_W-1:0] dividend_i,
  input  logic [gcm_pkg::DENOM_W-1:0]  divisor_i,
  output logic                     done_o,
  output gcm_pkg::div_res_t        res_o
);
  import gcm_pkg::*;

  localparam int unsigned CNT_W = $clog2(AMOUNT_W + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(AMOUNT_W - 1);

  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [AMOUNT_W-1:0] dvd_q, dvd_d;
  logic [DENOM_W-1:0] rem_q, rem_d;
  logic [DENOM_W-1:0] dvs_q, dvs_d;
  logic [DENOM_W:0]   trial;
  logic [DENOM_W+1:0] diff;
  logic               q_bit;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign trial = {rem_q, dvd_q[AMOUNT_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};
  assign q_bit = ~diff[DENOM_W+1];

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      dvd_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (run_q) begin
      dvd_d = {dvd_q[AMOUNT_W-2:0], q_bit};
      rem_d = q_bit ? diff[DENOM_W-1:0] : trial[DENOM_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o          = done_q;
  assign res_o.quotient  = dvd_q;
  assign res_o.remainder = rem_q;

endmodule

// ===== rtl/greedy_change_maker_unit.sv =====
// Greedy coin change over configured denominations, top level.
//
//  channel   | direction | handshake                   | contents
//  ----------+-----------+-----------------------------+-----------------------------------
//  request   | in        | start && !busy              | amount_cents_i
//  config    | in        | cfg_valid_i && cfg_ready_o  | cfg_index_i, cfg_data_i
//  result    | out       | out_strobe_o, one cycle     | piece_count_o, piece_value_o,
//            |           |                             | unpaid_rest_o, last_o
//
// For each denomination in use the block spends a selection step, a division in the
// shared bit-serial divider and a hand-over back to selection; a zero denomination is
// skipped at selection without a division. busy stays high for the
// whole request. After reset the block is ready at once with the reset
// denominations. The receiver cannot stall; each result word is shown for one cycle,
// the last one in the cycle in which busy has dropped again.
module greedy_change_maker_unit #(
  parameter int unsigned MAX_DENOMS = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [gcm_pkg::AMOUNT_W-1:0]  amount_cents_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gcm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gcm_pkg::DENOM_W-1:0]   cfg_data_i,
  output logic                          out_strobe_o,
  output logic [gcm_pkg::AMOUNT_W-1:0]  piece_count_o,
  output logic [gcm_pkg::DENOM_W-1:0]   piece_value_o,
  output logic [gcm_pkg::DENOM_W-1:0]   unpaid_rest_o,
  output logic                          last_o
);
  import gcm_pkg::*;

  localparam int unsigned IDX_W = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
  localparam logic [COUNT_W-1:0] MAX_N = COUNT_W'(MAX_DENOMS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [COUNT_W-1:0]  count_q;
  logic [DENOM_W-1:0]  denom_q [MAX_DENOMS];
  logic [COUNT_W-1:0]  idx_q, idx_d;
  logic [COUNT_W-1:0]  n_act;
  logic [AMOUNT_W-1:0] rest_q, rest_d;
  logic [DENOM_W-1:0]  cur_denom;
  logic                pend_q, pend_d;
  logic [AMOUNT_W-1:0] pend_cnt_q, pend_cnt_d;
  logic [DENOM_W-1:0]  pend_val_q, pend_val_d;
  logic                ov_q, ov_d;
  logic [AMOUNT_W-1:0] oc_q, oc_d;
  logic [DENOM_W-1:0]  oval_q, oval_d;
  logic [DENOM_W-1:0]  orest_q, orest_d;
  logic                olast_q, olast_d;
  logic [DENOM_W-1:0]  rest_sat;
  logic                div_start;
  logic                div_done;
  div_res_t            div_res;

  // Configuration writes; the block only sees them while idle.
  assign cfg_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= DENOM_COUNT_RESET;
      for (int i = 0; i < MAX_DENOMS; i++) begin
        denom_q[i] <= DENOM_RESET[i];
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_DENOM_COUNT) begin
        count_q <= cfg_data_i[COUNT_W-1:0];
      end
      for (int i = 0; i < MAX_DENOMS; i++) begin
        if (cfg_index_i == REG_DENOM_BASE + CFG_IDX_W'(i)) begin
          denom_q[i] <= cfg_data_i;
        end
      end
    end
  end

  // Number of denominations in use, clamped to one and to MAX_DENOMS.
  always_comb begin
    if (count_q == '0) begin
      n_act = COUNT_W'(1);
    end else if (count_q > MAX_N) begin
      n_act = MAX_N;
    end else begin
      n_act = count_q;
    end
  end

  assign cur_denom = denom_q[idx_q[IDX_W-1:0]];
  assign rest_sat  = (rest_q > AMOUNT_W'({DENOM_W{1'b1}})) ? {DENOM_W{1'b1}}
                                                            : rest_q[DENOM_W-1:0];

  // Sequencer: walk the denominations, one division for each nonzero one, and hold back the
  // latest result word until it is known whether another one follows.
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    rest_d     = rest_q;
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    pend_val_d = pend_val_q;
    div_start  = 1'b0;
    ov_d       = 1'b0;
    oc_d       = oc_q;
    oval_d     = oval_q;
    orest_d    = orest_q;
    olast_d    = olast_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_LOAD;
          idx_d   = '0;
          rest_d  = amount_cents_i;
          pend_d  = 1'b0;
        end
      end
      S_LOAD: begin
        if (idx_q >= n_act) begin
          state_d = S_FIN;
        end else if (cur_denom == '0) begin
          idx_d = idx_q + 1'b1;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_LOAD;
          idx_d   = idx_q + 1'b1;
          if (div_res.quotient != '0) begin
            rest_d = AMOUNT_W'(div_res.remainder);
            if (pend_q) begin
              ov_d    = 1'b1;
              oc_d    = pend_cnt_q;
              oval_d  = pend_val_q;
              orest_d = '0;
              olast_d = 1'b0;
            end
            pend_d     = 1'b1;
            pend_cnt_d = div_res.quotient;
            pend_val_d = cur_denom;
          end
        end
      end
      S_FIN: begin
        state_d = S_IDLE;
        ov_d    = 1'b1;
        oc_d    = pend_q ? pend_cnt_q : '0;
        oval_d  = pend_q ? pend_val_q : '0;
        orest_d = rest_sat;
        olast_d = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  // Datapath and output registers.
  always_ff @(posedge clk_i) begin
    rest_q     <= rest_d;
    pend_cnt_q <= pend_cnt_d;
    pend_val_q <= pend_val_d;
    oc_q       <= oc_d;
    oval_q     <= oval_d;
    orest_q    <= orest_d;
    olast_q    <= olast_d;
  end

  gcm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rest_q),
    .divisor_i  (cur_denom),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  assign busy          = (state_q != S_IDLE);
  assign out_strobe_o  = ov_q;
  assign piece_count_o = oc_q;
  assign piece_value_o = oval_q;
  assign unpaid_rest_o = orest_q;
  assign last_o        = olast_q;

endmodule

// ===== rtl/gcm_checker.sv =====
// Port-level checks of the greedy change maker and their binding.
module gcm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          out_strobe_o,
  input logic [gcm_pkg::AMOUNT_W-1:0]  piece_count_o,
  input logic [gcm_pkg::DENOM_W-1:0]   unpaid_rest_o,
  input logic                          last_o
);

  // A word that is not the last one only appears while a request is at work.
  a_mid_word_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && !last_o |-> busy)
    else $error("non-final result word outside a request");

  // A word that is not the last one pays at least one piece and carries no rest.
  a_mid_word_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && !last_o |-> piece_count_o != '0 && unpaid_rest_o == '0)
    else $error("non-final result word with empty count or a rest");

  // Every request ends with its final word as busy drops.
  a_end_has_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> out_strobe_o && last_o)
    else $error("request ended without a final word");

  // Nothing is shown in the cycle after a request is taken.
  a_quiet_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !out_strobe_o)
    else $error("result word right after a request was taken");

endmodule

bind greedy_change_maker_unit gcm_checker u_gcm_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench of the greedy change maker unit.
`timescale 1ns / 100ps

module tb_top;
  import gcm_pkg::*;

  // One result word of the change maker.
  typedef struct packed {
    logic [AMOUNT_W-1:0] count;
    logic [DENOM_W-1:0]  value;
    logic [DENOM_W-1:0]  rest;
    logic                last;
  } payout_t;

  // Tracks the denomination registers, predicts the payout of every accepted
  // amount and checks the result words against it in order.
  class change_board;
    logic [COUNT_W-1:0] count_reg;
    logic [DENOM_W-1:0] denom_reg [DENOM_SLOTS];
    payout_t            due [$];
    int                 fail_count;

    function new();
      count_reg = 3'd7;
      denom_reg = '{16'd50000, 16'd10000, 16'd2000, 16'd500, 16'd100, 16'd10, 16'd1};
      fail_count = 0;
    endfunction

    // Writes to indexes past the last denomination are dropped.
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DENOM_W-1:0] data);
      if (idx == REG_DENOM_COUNT) begin
        count_reg = data[COUNT_W-1:0];
      end else if (idx < REG_DENOM_BASE + DENOM_SLOTS) begin
        denom_reg[idx - REG_DENOM_BASE] = data;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction

    // Greedy split of one amount over the denominations in use.
    function void note_amount(logic [AMOUNT_W-1:0] amount);
      logic [AMOUNT_W-1:0] rest;
      logic [AMOUNT_W-1:0] pieces;
      payout_t             words [DENOM_SLOTS];
      int                  in_use;
      int                  used;
      rest = amount;
      used = 0;
      in_use = (count_reg == 0) ? 1 : int'(count_reg);
      for (int i = 0; i < in_use; i++) begin
        // A zero denomination is skipped without a division.
        if (denom_reg[i] == 0) continue;
        pieces = rest / denom_reg[i];
        if (pieces == 0) continue;
        rest = rest - pieces * denom_reg[i];
        words[used] = '{pieces, denom_reg[i], '0, 1'b0};
        used++;
      end
      // Nothing paid at all: one empty word.
      if (used == 0) begin
        words[0] = '0;
        used = 1;
      end
      // The final word carries the unpaid rest, saturated to 16 bits.
      words[used-1].rest = (rest > 24'hFFFF) ? 16'hFFFF : rest[DENOM_W-1:0];
      words[used-1].last = 1'b1;
      for (int i = 0; i < used; i++) due = {due, words[i]};
    endfunction

    // Fields are shown as count/value/rest/last.
    function void check_piece(payout_t seen);
      payout_t want;
      if (due.size() == 0) begin
        fail_count++;
        if (fail_count <= 50)
          $display("%0t: result word with no amount pending: %0d/%0d/%0d/%0b",
                   $time, seen.count, seen.value, seen.rest, seen.last);
        return;
      end
      want = due.pop_front();
      if (seen !== want) begin
        fail_count++;
        if (fail_count <= 50)
          $display("%0t: mismatch: expected %0d/%0d/%0d/%0b, actual %0d/%0d/%0d/%0b",
                   $time, want.count, want.value, want.rest, want.last,
                   seen.count, seen.value, seen.rest, seen.last);
      end
    endfunction
  endclass

  localparam logic [AMOUNT_W-1:0] EDGE_AMOUNTS [12] = '{
    24'd0, 24'd1, 24'd9, 24'd10, 24'd99, 24'd100, 24'd12345, 24'd50000,
    24'd65535, 24'd88888, 24'd1000000, 24'hFFFFFF
  };
  localparam int unsigned PHASE_IDLE [3] = '{0, 55, 28};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [AMOUNT_W-1:0]  amount_cents_i;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DENOM_W-1:0]   cfg_data_i;
  logic                 out_strobe_o;
  logic [AMOUNT_W-1:0]  piece_count_o;
  logic [DENOM_W-1:0]   piece_value_o;
  logic [DENOM_W-1:0]   unpaid_rest_o;
  logic                 last_o;

  change_board board;
  payout_t     seen_word;

  greedy_change_maker_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .amount_cents_i (amount_cents_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_strobe_o   (out_strobe_o),
    .piece_count_o  (piece_count_o),
    .piece_value_o  (piece_value_o),
    .unpaid_rest_o  (unpaid_rest_o),
    .last_o         (last_o)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Guard against a hung block.
  initial begin
    #12000000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Monitor: check result words and note accepted amounts at each rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && board != null) begin
      if (out_strobe_o) begin
        seen_word = {piece_count_o, piece_value_o, unpaid_rest_o, last_o};
        board.check_piece(seen_word);
      end
      if (start && !busy) board.note_amount(amount_cents_i);
    end
  end

  // Offers one amount after an optional gap and returns at the falling edge
  // after it was taken. start stays high when the next word follows at once.
  task automatic send_amount(input logic [AMOUNT_W-1:0] amount, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    amount_cents_i <= amount;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drops start and waits until every predicted word has come out.
  task automatic wait_idle();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // One register write; cfg_valid_i stays high for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DENOM_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic load_regs(input logic [DENOM_W-1:0] count_data,
                           input logic [DENOM_W-1:0] d0, input logic [DENOM_W-1:0] d1,
                           input logic [DENOM_W-1:0] d2, input logic [DENOM_W-1:0] d3,
                           input logic [DENOM_W-1:0] d4, input logic [DENOM_W-1:0] d5,
                           input logic [DENOM_W-1:0] d6);
    write_reg(REG_DENOM_COUNT, count_data);
    write_reg(REG_DENOM_BASE + 4'd0, d0);
    write_reg(REG_DENOM_BASE + 4'd1, d1);
    write_reg(REG_DENOM_BASE + 4'd2, d2);
    write_reg(REG_DENOM_BASE + 4'd3, d3);
    write_reg(REG_DENOM_BASE + 4'd4, d4);
    write_reg(REG_DENOM_BASE + 4'd5, d5);
    write_reg(REG_DENOM_BASE + 4'd6, d6);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [DENOM_W-1:0] pick_denom();
    case ($urandom_range(4))
      0:       return '0;
      1:       return DENOM_W'($urandom_range(1, 20));
      2:       return DENOM_W'($urandom_range(1, 1000));
      3:       return DENOM_W'($urandom_range(1, 65535));
      default: return DENOM_W'($urandom_range(1000, 65535));
    endcase
  endfunction

  function automatic logic [AMOUNT_W-1:0] pick_amount();
    case ($urandom_range(3))
      0:       return AMOUNT_W'($urandom_range(0, 999));
      1:       return AMOUNT_W'($urandom_range(0, 199999));
      2:       return AMOUNT_W'($urandom);
      default: return AMOUNT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Random amounts; the sender idles in idle_pct of a hundred words.
  task automatic run_random(input int unsigned idle_pct, input int words);
    int gap;
    for (int k = 0; k < words; k++) begin
      gap = ($urandom_range(99) < idle_pct) ? int'($urandom_range(1, 250)) : 0;
      send_amount(pick_amount(), gap);
    end
  endtask

  // Stimulus.
  initial begin
    board = new();
    rst_ni = 1'b0;
    start = 1'b0;
    amount_cents_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset denominations: field extremes and typical amounts.
    foreach (EDGE_AMOUNTS[i]) send_amount(EDGE_AMOUNTS[i], 0);
    run_random(PHASE_IDLE[0], 60);
    wait_idle();

    // Count of zero means one denomination, here the largest value.
    load_regs(16'd0, 16'hFFFF, pick_denom(), pick_denom(), pick_denom(),
              pick_denom(), pick_denom(), pick_denom());
    send_amount(24'd65534, 0);
    send_amount(24'd65535, 0);
    send_amount(24'hFFFFFF, 0);
    send_amount(24'd0, 0);
    run_random(PHASE_IDLE[1], 45);
    wait_idle();

    // Zero denominations and an order that is not descending; upper count bits ignored.
    load_regs(16'hFFF5, 16'd0, 16'd3, 16'd7, 16'd0, 16'd1000, 16'd5, 16'd2);
    send_amount(24'd6, 0);
    send_amount(24'd2, 0);
    send_amount(24'd1001, 0);
    send_amount(24'd20, 0);
    run_random(PHASE_IDLE[0], 45);
    wait_idle();

    // Every denomination in use is zero: the rest saturates.
    load_regs(16'd3, 16'd0, 16'd0, 16'd0, pick_denom(), pick_denom(), pick_denom(),
              pick_denom());
    send_amount(24'd0, 0);
    send_amount(24'd65535, 0);
    send_amount(24'd65536, 0);
    send_amount(24'hFFFFFF, 0);
    run_random(PHASE_IDLE[2], 30);
    wait_idle();

    // Writes to unknown indexes, then a count that wraps to zero and a unit coin.
    write_reg(CFG_IDX_W'(REG_DENOM_BASE + DENOM_SLOTS), 16'hFFFF);
    write_reg(4'hF, 16'h0001);
    write_reg(4'hC, DENOM_W'($urandom));
    load_regs(16'd8, 16'd1, pick_denom(), pick_denom(), pick_denom(),
              pick_denom(), pick_denom(), pick_denom());
    send_amount(24'hFFFFFF, 0);
    send_amount(24'd0, 0);
    send_amount(24'd77, 0);
    run_random(PHASE_IDLE[1], 30);
    wait_idle();

    // Random register settings.
    for (int p = 0; p < 6; p++) begin
      load_regs(DENOM_W'($urandom), pick_denom(), pick_denom(), pick_denom(),
                pick_denom(), pick_denom(), pick_denom(), pick_denom());
      run_random(PHASE_IDLE[p % 3], 40);
      wait_idle();
    end

    repeat (200) @(posedge clk_i);
    if (board.fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
